>>> rtl/core/oss_pkg.sv
// Shared types, constants and helper functions of the oar stroke servo sequencer.
`timescale 1ns / 1ps

package oss_pkg;

  // Width of all time values (durations, remaining time, elapsed time).
  localparam int TIME_W    = 16;
  localparam int ANGLE_W   = 8;
  localparam int SWING_W   = 7;
  localparam int CFG_IDX_W = 3;

  // The product done * (2 * swing) and the number of divider iterations.
  localparam int PROD_W    = TIME_W + SWING_W + 1;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Signed width for angle arithmetic before clamping.
  localparam int SANGLE_W  = ANGLE_W + 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RAISE_MS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREPARE_MS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STROKE_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_CENTER      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_SWING       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_REST       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_ROW_CENTER = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_ROW_SWING  = 3'd7;

  // Reset values of the configuration registers and the angle state.
  localparam logic [TIME_W-1:0]  RST_RAISE_MS        = 16'd20;
  localparam logic [TIME_W-1:0]  RST_PREPARE_MS      = 16'd100;
  localparam logic [TIME_W-1:0]  RST_STROKE_MS       = 16'd500;
  localparam logic [ANGLE_W-1:0] RST_YAW_CENTER      = 8'd90;
  localparam logic [SWING_W-1:0] RST_YAW_SWING       = 7'd10;
  localparam logic [ANGLE_W-1:0] RST_ROLL_REST       = 8'd90;
  localparam logic [ANGLE_W-1:0] RST_ROLL_ROW_CENTER = 8'd85;
  localparam logic [SWING_W-1:0] RST_ROLL_ROW_SWING  = 7'd25;
  localparam logic [ANGLE_W-1:0] RST_ANGLE           = 8'd90;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;

  // Motion phases as reported on the result channel.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RAISE   = 3'd1,
    PH_PRE_L   = 3'd2,
    PH_LEFT    = 3'd3,
    PH_PRE_R   = 3'd4,
    PH_RIGHT   = 3'd5
  } phase_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  // Clamp a signed angle to 0..180 degrees.
  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic signed [SANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] res;
    if (a < 0) begin
      res = '0;
    end else if (a > $signed({3'b000, ANGLE_MAX})) begin
      res = ANGLE_MAX;
    end else begin
      res = a[ANGLE_W-1:0];
    end
    return res;
  endfunction

  // A duration of zero counts as one millisecond.
  function automatic logic [TIME_W-1:0] duration(input logic [TIME_W-1:0] d);
    return (d == '0) ? TIME_W'(1) : d;
  endfunction

endpackage

>>> rtl/core/oar_stroke_servo_sequencer.sv
// Top level of the oar stroke servo sequencer: phase stepping and stroke yaw interpolation.
`timescale 1ns / 1ps

// Usage:
// Each input item is a tick carrying elapsed milliseconds; each tick yields one
// result item with yaw, roll, phase and active. Configuration is a plain write
// port (cfg_we, cfg_index, cfg_wdata); the user must write it only while the
// block is idle, which the block does not enforce. An item is accepted when
// in_valid is high and in_stall is low. After an item is accepted, in_stall
// stays high until its result is loaded into the output register; one tick
// is handled at a time.
// Sequence: in ST_STEP the tick crosses the phases it covers, one per step,
// until it ends inside a phase or exactly at a phase end; ST_DONE then hands
// over the result. A tick that ends inside a stroke first passes ST_MUL (the
// multiply), the iterations of the shared bit-serial divider in ST_DIV and
// ST_FIN (forming the angle). The phase stepper, which crosses one phase per
// cycle, sets the time taken by long ticks against short durations.
// The output register holds its item while out_stall is high; the next tick may
// be accepted meanwhile and waits in its final state until the register frees.
// Reset (synchronous, rst_n low) returns configuration to its defaults, the
// phase to idle, both angles to 90 degrees and empties the output register.

module oar_stroke_servo_sequencer
  import oss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Tick input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TIME_W-1:0]    in_elapsed_ms,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ANGLE_W-1:0]   out_yaw_angle,
  output logic [ANGLE_W-1:0]   out_roll_angle,
  output logic [2:0]           out_phase,
  output logic                 out_active,
  // Configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_wdata
);

  // Configuration registers
  logic [TIME_W-1:0]  raise_ms_r, prepare_ms_r, stroke_ms_r;
  logic [ANGLE_W-1:0] yaw_center_r, roll_rest_r, roll_row_center_r;
  logic [SWING_W-1:0] yaw_swing_r, roll_row_swing_r;

  // Sequencer and model state
  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [TIME_W-1:0]  rem_r, rem_nxt;
  logic [TIME_W-1:0]  e_r, e_nxt;
  logic [ANGLE_W-1:0] yaw_r, yaw_nxt;
  logic [ANGLE_W-1:0] roll_r, roll_nxt;
  logic               active_r, active_nxt;

  // Shared divider datapath
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [TIME_W-1:0]    racc_r, racc_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 done_neg_r, done_neg_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [ANGLE_W-1:0] out_yaw_r, out_roll_r;
  phase_t             out_phase_r;
  logic               out_active_r;

  // Derived values
  logic                      in_accept;
  logic                      out_load;
  logic                      ph_valid;
  logic                      step_cross;
  logic [TIME_W-1:0]         e_left;
  phase_t                    ph_after;
  phase_t                    ph_enter;
  logic [TIME_W-1:0]         stroke_len;
  logic [TIME_W:0]           stroke_diff;
  logic [TIME_W-1:0]         stroke_done;
  logic [ANGLE_W-1:0]        yaw_pre_l, yaw_pre_r, roll_row_l, roll_row_r;
  logic [ANGLE_W:0]          quo_sat;
  logic                      sweep_neg;
  logic signed [SANGLE_W-1:0] yaw_base;
  logic signed [SANGLE_W-1:0] yaw_fin;
  logic [TIME_W:0]           div_trial;
  logic                      div_fits;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Phase step decision
  assign ph_valid   = (phase_r == PH_RAISE) || (phase_r == PH_PRE_L) || (phase_r == PH_LEFT) ||
                      (phase_r == PH_PRE_R) || (phase_r == PH_RIGHT);
  assign step_cross = ph_valid && (e_r >= rem_r);
  assign e_left     = e_r - rem_r;
  assign ph_after   = (phase_r == PH_RIGHT) ? PH_PRE_L : phase_t'(phase_r + 3'd1);
  assign ph_enter   = ph_valid ? ph_after : PH_RAISE;

  // Angle helpers
  assign yaw_pre_l  = clamp_angle($signed({3'b000, yaw_center_r}) -
                                  $signed({4'b0000, yaw_swing_r}));
  assign yaw_pre_r  = clamp_angle($signed({3'b000, yaw_center_r}) +
                                  $signed({4'b0000, yaw_swing_r}));
  assign roll_row_l = clamp_angle($signed({3'b000, roll_row_center_r}) -
                                  $signed({4'b0000, roll_row_swing_r}));
  assign roll_row_r = clamp_angle($signed({3'b000, roll_row_center_r}) +
                                  $signed({4'b0000, roll_row_swing_r}));

  // Time done in the stroke as sign and magnitude. It goes negative when the
  // stroke length was shortened after the stroke was entered.
  assign stroke_len  = duration(stroke_ms_r);
  assign stroke_diff = {1'b0, stroke_len} - {1'b0, rem_r};
  assign stroke_done = stroke_diff[TIME_W] ? (~stroke_diff[TIME_W-1:0] + TIME_W'(1))
                                           : stroke_diff[TIME_W-1:0];

  // One restoring division step
  assign div_trial = {racc_r, prod_r[PROD_W-1]};
  assign div_fits  = (div_trial >= {1'b0, stroke_len});

  // A quotient this large drives the angle past either end of the range anyway.
  assign quo_sat   = (prod_r[PROD_W-1:ANGLE_W+1] != '0) ? '1 : prod_r[ANGLE_W:0];
  assign sweep_neg = done_neg_r ^ (phase_r == PH_RIGHT);

  // Final yaw: begin plus the floored fraction of the swing travel.
  always_comb begin
    if (phase_r == PH_RIGHT) begin
      yaw_base = $signed({3'b000, yaw_center_r}) + $signed({4'b0000, yaw_swing_r});
    end else begin
      yaw_base = $signed({3'b000, yaw_center_r}) - $signed({4'b0000, yaw_swing_r});
    end
    if (sweep_neg) begin
      yaw_fin = yaw_base - $signed({2'b00, quo_sat})
              - $signed({{(SANGLE_W-1){1'b0}}, (racc_r != '0)});
    end else begin
      yaw_fin = yaw_base + $signed({2'b00, quo_sat});
    end
  end

  // Next-state logic of the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (!ph_valid) begin
          if (e_r == '0) state_nxt = ST_DONE;
        end else if (step_cross) begin
          if (e_left == '0) state_nxt = ST_DONE;
        end else if ((phase_r == PH_LEFT) || (phase_r == PH_RIGHT)) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates driven by the sequencer state
  always_comb begin
    phase_nxt    = phase_r;
    rem_nxt      = rem_r;
    e_nxt        = e_r;
    yaw_nxt      = yaw_r;
    roll_nxt     = roll_r;
    active_nxt   = active_r;
    prod_nxt     = prod_r;
    racc_nxt     = racc_r;
    div_cnt_nxt  = div_cnt_r;
    done_neg_nxt = done_neg_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) e_nxt = in_elapsed_ms;
      end
      ST_STEP: begin
        if (!ph_valid || step_cross) begin
          // Leave the phase and enter the next one.
          if (!ph_valid) begin
            active_nxt = 1'b1;
          end else begin
            e_nxt = e_left;
          end
          phase_nxt = ph_enter;
          unique case (ph_enter)
            PH_RAISE: begin
              yaw_nxt  = clamp_angle($signed({3'b000, yaw_center_r}));
              roll_nxt = clamp_angle($signed({3'b000, roll_rest_r}));
              rem_nxt  = duration(raise_ms_r);
            end
            PH_PRE_L: begin
              yaw_nxt  = yaw_pre_l;
              roll_nxt = clamp_angle($signed({3'b000, roll_rest_r}));
              rem_nxt  = duration(prepare_ms_r);
            end
            PH_PRE_R: begin
              yaw_nxt  = yaw_pre_r;
              roll_nxt = clamp_angle($signed({3'b000, roll_rest_r}));
              rem_nxt  = duration(prepare_ms_r);
            end
            default: begin
              rem_nxt = stroke_len;
            end
          endcase
        end else begin
          // The tick ends inside the current phase.
          rem_nxt = rem_r - e_r;
          e_nxt   = '0;
        end
      end
      ST_MUL: begin
        prod_nxt     = PROD_W'(stroke_done) * PROD_W'({yaw_swing_r, 1'b0});
        done_neg_nxt = stroke_diff[TIME_W];
        racc_nxt     = '0;
        div_cnt_nxt  = '0;
      end
      ST_DIV: begin
        racc_nxt    = div_fits ? TIME_W'(div_trial - {1'b0, stroke_len}) : div_trial[TIME_W-1:0];
        prod_nxt    = {prod_r[PROD_W-2:0], div_fits};
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
      end
      ST_FIN: begin
        yaw_nxt  = clamp_angle(yaw_fin);
        roll_nxt = (phase_r == PH_RIGHT) ? roll_row_r : roll_row_l;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  // Control and model state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      rem_r       <= '0;
      yaw_r       <= RST_ANGLE;
      roll_r      <= RST_ANGLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      rem_r       <= rem_nxt;
      yaw_r       <= yaw_nxt;
      roll_r      <= roll_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    prod_r     <= prod_nxt;
    racc_r     <= racc_nxt;
    done_neg_r <= done_neg_nxt;
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_yaw_r    <= yaw_r;
      out_roll_r   <= roll_r;
      out_phase_r  <= phase_r;
      out_active_r <= active_r;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raise_ms_r        <= RST_RAISE_MS;
      prepare_ms_r      <= RST_PREPARE_MS;
      stroke_ms_r       <= RST_STROKE_MS;
      yaw_center_r      <= RST_YAW_CENTER;
      yaw_swing_r       <= RST_YAW_SWING;
      roll_rest_r       <= RST_ROLL_REST;
      roll_row_center_r <= RST_ROLL_ROW_CENTER;
      roll_row_swing_r  <= RST_ROLL_ROW_SWING;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAISE_MS:        raise_ms_r        <= cfg_wdata;
        CFG_PREPARE_MS:      prepare_ms_r      <= cfg_wdata;
        CFG_STROKE_MS:       stroke_ms_r       <= cfg_wdata;
        CFG_YAW_CENTER:      yaw_center_r      <= cfg_wdata[ANGLE_W-1:0];
        CFG_YAW_SWING:       yaw_swing_r       <= cfg_wdata[SWING_W-1:0];
        CFG_ROLL_REST:       roll_rest_r       <= cfg_wdata[ANGLE_W-1:0];
        CFG_ROLL_ROW_CENTER: roll_row_center_r <= cfg_wdata[ANGLE_W-1:0];
        CFG_ROLL_ROW_SWING:  roll_row_swing_r  <= cfg_wdata[SWING_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_yaw_angle  = out_yaw_r;
  assign out_roll_angle = out_roll_r;
  assign out_phase      = out_phase_r;
  assign out_active     = out_active_r;

endmodule

>>> rtl/core/oss_checker.sv
// Port-level checker for the oar stroke servo sequencer and its bind statement.
`timescale 1ns / 1ps

module oss_checker
  import oss_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [ANGLE_W-1:0]   out_yaw_angle,
  input logic [ANGLE_W-1:0]   out_roll_angle,
  input logic [2:0]           out_phase,
  input logic                 out_active
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_yaw_angle) &&
    $stable(out_roll_angle) && $stable(out_phase) && $stable(out_active))
    else $error("stalled result changed");

  // The first tick leaves idle and active stays set, so each result is active.
  a_out_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_active)
    else $error("result not marked active");

  // Angles stay inside the servo range.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_angle <= ANGLE_MAX) && (out_roll_angle <= ANGLE_MAX))
    else $error("angle out of range");

  // The block works on one tick at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("tick taken while another is in work");

endmodule

bind oar_stroke_servo_sequencer oss_checker u_oss_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for the oar stroke servo sequencer with its own phase predictor.
`timescale 1ns / 1ps

module testbench;
  import oss_pkg::*;

  // Setting of all eight registers, at the widths of the register file.
  typedef struct packed {
    logic [TIME_W-1:0]  raise_ms;
    logic [TIME_W-1:0]  prepare_ms;
    logic [TIME_W-1:0]  stroke_ms;
    logic [ANGLE_W-1:0] yaw_center;
    logic [SWING_W-1:0] yaw_swing;
    logic [ANGLE_W-1:0] roll_rest;
    logic [ANGLE_W-1:0] roll_row_center;
    logic [SWING_W-1:0] roll_row_swing;
  } seq_cfg_t;

  // One servo command as it leaves the block.
  typedef struct packed {
    logic [ANGLE_W-1:0] yaw;
    logic [ANGLE_W-1:0] roll;
    phase_t             phase;
    logic               active;
  } servo_cmd_t;

  localparam longint RUN_LIMIT_NS = 20_000_000;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_W-1:0]    in_elapsed_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ANGLE_W-1:0]   out_yaw_angle;
  logic [ANGLE_W-1:0]   out_roll_angle;
  logic [2:0]           out_phase;
  logic                 out_active;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_wdata = '0;

  // Predicted sequencer state and the commands still to come out.
  seq_cfg_t     cfg_q;
  phase_t       ph_q;
  longint       rem_q;
  logic [7:0]   yaw_q;
  logic [7:0]   roll_q;
  logic         act_q;
  servo_cmd_t   expected_cmds[$];
  int           mismatch_count = 0;

  // Idling controls shared by the stimulus and the receiver.
  bit in_gaps_on = 1'b1;
  bit stall_bursts_on = 1'b1;
  int hold_req = 0;
  int hold_cnt = 0;
  int burst_cnt = 0;

  oar_stroke_servo_sequencer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_elapsed_ms  (in_elapsed_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_yaw_angle  (out_yaw_angle),
    .out_roll_angle (out_roll_angle),
    .out_phase      (out_phase),
    .out_active     (out_active),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Guard against a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic seq_cfg_t default_cfg();
    seq_cfg_t c;
    c.raise_ms        = RST_RAISE_MS;
    c.prepare_ms      = RST_PREPARE_MS;
    c.stroke_ms       = RST_STROKE_MS;
    c.yaw_center      = RST_YAW_CENTER;
    c.yaw_swing       = RST_YAW_SWING;
    c.roll_rest       = RST_ROLL_REST;
    c.roll_row_center = RST_ROLL_ROW_CENTER;
    c.roll_row_swing  = RST_ROLL_ROW_SWING;
    return c;
  endfunction

  function automatic logic [7:0] clamp_deg(longint a);
    if (a < 0) return 8'd0;
    if (a > 180) return 8'd180;
    return 8'(a);
  endfunction

  // A zero duration counts as one millisecond.
  function automatic longint dur_ms(logic [TIME_W-1:0] d);
    return (d == '0) ? 64'sd1 : longint'(d);
  endfunction

  // Yaw at the start of a stroke on the given side.
  function automatic longint side_yaw(bit right);
    return right ? longint'(cfg_q.yaw_center) + longint'(cfg_q.yaw_swing)
                 : longint'(cfg_q.yaw_center) - longint'(cfg_q.yaw_swing);
  endfunction

  function automatic void enter_phase(phase_t p);
    ph_q = p;
    case (p)
      PH_RAISE: begin
        yaw_q  = clamp_deg(longint'(cfg_q.yaw_center));
        roll_q = clamp_deg(longint'(cfg_q.roll_rest));
        rem_q  = dur_ms(cfg_q.raise_ms);
      end
      PH_PRE_L, PH_PRE_R: begin
        yaw_q  = clamp_deg(side_yaw(p == PH_PRE_R));
        roll_q = clamp_deg(longint'(cfg_q.roll_rest));
        rem_q  = dur_ms(cfg_q.prepare_ms);
      end
      default: begin
        rem_q = dur_ms(cfg_q.stroke_ms);
      end
    endcase
  endfunction

  // Linear yaw sweep across a stroke, rounded toward minus infinity.
  function automatic void stroke_yaw_roll(bit right);
    longint len, done, from_deg, to_deg, num, quo;
    len      = dur_ms(cfg_q.stroke_ms);
    done     = len - rem_q;
    from_deg = side_yaw(right);
    to_deg   = side_yaw(!right);
    num      = from_deg * len + done * (to_deg - from_deg);
    quo      = num / len;
    if (num % len != 0 && num < 0) quo = quo - 1;
    yaw_q = clamp_deg(quo);
    if (right) begin
      roll_q = clamp_deg(longint'(cfg_q.roll_row_center) + longint'(cfg_q.roll_row_swing));
    end else begin
      roll_q = clamp_deg(longint'(cfg_q.roll_row_center) - longint'(cfg_q.roll_row_swing));
    end
  endfunction

  // Spend one tick across as many phases as it covers and queue the command.
  function automatic void step_sequencer(logic [TIME_W-1:0] ms);
    longint     left;
    servo_cmd_t cmd;
    left = longint'(ms);
    do begin
      if (ph_q == PH_IDLE || ph_q > PH_RIGHT) begin
        act_q = 1'b1;
        enter_phase(PH_RAISE);
      end else if (left >= rem_q) begin
        left  = left - rem_q;
        rem_q = 0;
        enter_phase(ph_q == PH_RIGHT ? PH_PRE_L : phase_t'(ph_q + 3'd1));
      end else begin
        rem_q = rem_q - left;
        left  = 0;
        if (ph_q == PH_LEFT || ph_q == PH_RIGHT) stroke_yaw_roll(ph_q == PH_RIGHT);
      end
    end while (left != 0);
    cmd.yaw    = yaw_q;
    cmd.roll   = roll_q;
    cmd.phase  = ph_q;
    cmd.active = act_q;
    expected_cmds.push_back(cmd);
  endfunction

  // Receiver: long hold-offs on request, otherwise random stall bursts.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt = hold_cnt - 1;
    end else if (burst_cnt != 0) begin
      out_stall <= 1'b1;
      burst_cnt = burst_cnt - 1;
    end else if (stall_bursts_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      burst_cnt = $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each delivered item with the oldest predicted command.
  always @(posedge clk) begin
    servo_cmd_t exp_cmd;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected result item: yaw %0d roll %0d phase %0d active %0d",
               out_yaw_angle, out_roll_angle, out_phase, out_active);
        mismatch_count++;
      end else begin
        exp_cmd = expected_cmds.pop_front();
        if (out_yaw_angle !== exp_cmd.yaw) begin
          $error("out_yaw_angle: expected %0d, got %0d", exp_cmd.yaw, out_yaw_angle);
          mismatch_count++;
        end
        if (out_roll_angle !== exp_cmd.roll) begin
          $error("out_roll_angle: expected %0d, got %0d", exp_cmd.roll, out_roll_angle);
          mismatch_count++;
        end
        if (out_phase !== exp_cmd.phase) begin
          $error("out_phase: expected %0d, got %0d", exp_cmd.phase, out_phase);
          mismatch_count++;
        end
        if (out_active !== exp_cmd.active) begin
          $error("out_active: expected %0d, got %0d", exp_cmd.active, out_active);
          mismatch_count++;
        end
      end
    end
  end

  // Offer one tick, with an optional idle gap first, and predict it on acceptance.
  task automatic send_tick(input logic [TIME_W-1:0] ms);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_elapsed_ms <= ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_sequencer(ms);
  endtask

  // Stop offering ticks until every predicted command has come out.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
  endtask

  // Write all registers back to back; only called while the block is idle.
  task automatic load_config(input seq_cfg_t c);
    logic [TIME_W-1:0] val;
    for (int i = 0; i < 8; i++) begin
      case (CFG_IDX_W'(i))
        CFG_RAISE_MS:        val = c.raise_ms;
        CFG_PREPARE_MS:      val = c.prepare_ms;
        CFG_STROKE_MS:       val = c.stroke_ms;
        CFG_YAW_CENTER:      val = TIME_W'(c.yaw_center);
        CFG_YAW_SWING:       val = TIME_W'(c.yaw_swing);
        CFG_ROLL_REST:       val = TIME_W'(c.roll_rest);
        CFG_ROLL_ROW_CENTER: val = TIME_W'(c.roll_row_center);
        default:             val = TIME_W'(c.roll_row_swing);
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= val;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_q = c;
  endtask

  // Random setting; short durations make ticks cross many phases.
  function automatic seq_cfg_t random_cfg(bit short_times);
    seq_cfg_t c;
    if (short_times) begin
      c.raise_ms   = TIME_W'($urandom_range(1, 300));
      c.prepare_ms = TIME_W'($urandom_range(1, 300));
      c.stroke_ms  = TIME_W'($urandom_range(1, 300));
    end else begin
      c.raise_ms   = TIME_W'($urandom_range(256, 65535));
      c.prepare_ms = TIME_W'($urandom_range(256, 65535));
      c.stroke_ms  = TIME_W'($urandom_range(256, 65535));
    end
    c.yaw_center      = ANGLE_W'($urandom_range(0, 180));
    c.yaw_swing       = SWING_W'($urandom_range(0, 90));
    c.roll_rest       = ANGLE_W'($urandom_range(0, 180));
    c.roll_row_center = ANGLE_W'($urandom_range(0, 180));
    c.roll_row_swing  = SWING_W'($urandom_range(0, 90));
    return c;
  endfunction

  // Tick lengths mostly within one phase length so that the phase crossings stay bounded.
  function automatic logic [TIME_W-1:0] pick_elapsed();
    longint lo, hi;
    lo = dur_ms(cfg_q.raise_ms);
    hi = lo;
    if (dur_ms(cfg_q.prepare_ms) < lo) lo = dur_ms(cfg_q.prepare_ms);
    if (dur_ms(cfg_q.stroke_ms) < lo) lo = dur_ms(cfg_q.stroke_ms);
    if (dur_ms(cfg_q.prepare_ms) > hi) hi = dur_ms(cfg_q.prepare_ms);
    if (dur_ms(cfg_q.stroke_ms) > hi) hi = dur_ms(cfg_q.stroke_ms);
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return TIME_W'($urandom_range(0, 15));
      3:       return (lo >= 256) ? TIME_W'($urandom()) : TIME_W'($urandom_range(0, int'(hi)));
      default: return TIME_W'($urandom_range(0, int'(hi)));
    endcase
  endfunction

  // Leaving idle, zero ticks, exact phase ends and a full cycle at reset defaults.
  task automatic test_first_ticks();
    send_tick(16'd0);
    send_tick(16'd0);
    send_tick(16'd19);
    send_tick(16'd1);
    send_tick(16'd100);
    send_tick(16'd0);
    send_tick(16'd250);
    send_tick(16'd249);
    send_tick(16'd1);
    send_tick(16'd600);
    send_tick(16'd300);
    wait_all_results();
  endtask

  // Durations of zero and of the maximum, with the longest tick and short ones.
  task automatic test_duration_extremes();
    seq_cfg_t c;
    c = default_cfg();
    c.raise_ms   = '0;
    c.prepare_ms = '0;
    c.stroke_ms  = '0;
    load_config(c);
    send_tick(16'hFFFF);
    send_tick(16'd3);
    wait_all_results();
    c.raise_ms   = '1;
    c.prepare_ms = '1;
    c.stroke_ms  = '1;
    load_config(c);
    send_tick(16'hFFFF);
    send_tick(16'h8000);
    send_tick(16'd1);
    wait_all_results();
  endtask

  // Angles that fall outside 0..180 before clamping.
  task automatic test_angle_clamps();
    seq_cfg_t c;
    c = default_cfg();
    c.raise_ms        = 16'd1;
    c.prepare_ms      = 16'd2;
    c.stroke_ms       = 16'd7;
    c.yaw_center      = 8'd180;
    c.yaw_swing       = 7'd90;
    c.roll_rest       = 8'd180;
    c.roll_row_center = 8'd0;
    c.roll_row_swing  = 7'd90;
    load_config(c);
    for (int i = 1; i <= 7; i++) send_tick(TIME_W'(i));
    wait_all_results();
    c.yaw_center      = 8'd0;
    c.roll_rest       = 8'd0;
    c.roll_row_center = 8'd180;
    load_config(c);
    send_tick(16'd3);
    send_tick(16'd5);
    send_tick(16'd9);
    wait_all_results();
  endtask

  // Receiver holds off for a long stretch while ticks keep coming back to back.
  task automatic test_output_hold_off();
    load_config(default_cfg());
    in_gaps_on = 1'b0;
    hold_req = 300;
    repeat (12) send_tick(TIME_W'($urandom_range(0, 40)));
    wait_all_results();
    in_gaps_on = 1'b1;
  endtask

  // Random tick streams under a series of random settings; the last ones without idling.
  task automatic test_random_sequences();
    for (int p = 0; p < 10; p++) begin
      wait_all_results();
      in_gaps_on      = (p < 8);
      stall_bursts_on = (p < 8);
      load_config(random_cfg(p % 2 == 0));
      repeat (100) send_tick(pick_elapsed());
    end
  endtask

  initial begin
    cfg_q  = default_cfg();
    ph_q   = PH_IDLE;
    rem_q  = 0;
    yaw_q  = RST_ANGLE;
    roll_q = RST_ANGLE;
    act_q  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_ticks();
    test_duration_extremes();
    test_angle_clamps();
    test_output_hold_off();
    test_random_sequences();
    wait_all_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/oss_pkg.sv
rtl/core/oar_stroke_servo_sequencer.sv
rtl/core/oss_checker.sv
test/testbench.sv
